// ----- rtl/core/pmst_pkg.sv -----
// Shared types and constants for the Prim minimum spanning tree block.
// Holds the controller state enum, the command and status structs and field widths.
// No dependencies.
package pmst_pkg;

    // Field widths fixed by the external interface.
    localparam int VERTEX_FIELD_W = 4;
    localparam int WEIGHT_FIELD_W = 8;
    localparam int VCOUNT_W       = 5;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 5;

    // A vertex number on the ports has four bits, so at most sixteen are ever used.
    localparam int VERTEX_CAP = 16;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_WEIGHT_BITS  = 8;

    localparam logic [VCOUNT_W-1:0]       VCOUNT_RESET = 5'd16;
    localparam logic [VERTEX_FIELD_W-1:0] ROOT_RESET   = 4'd0;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_VERTEX  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_FIND,
        ST_EMIT,
        ST_RELAX,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic load;
        logic init;
        logic find;
        logic emit;
        logic relax;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic round_last;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/core/pmst_ctrl.sv -----
// Controller state machine for the Prim minimum spanning tree block.
// Sequences loading, the per-round minimum search, result issue and key relaxation.
// Depends on pmst_pkg.
module pmst_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    input  pmst_pkg::status_t status,
    output pmst_pkg::cmd_t    cmd
);
    import pmst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_FIND;
            end
            ST_FIND:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.round_last ? ST_IDLE : ST_RELAX;
                end
            end
            ST_RELAX:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIND;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.busy  = (state_reg != ST_IDLE);
        cmd.load  = (state_reg == ST_IDLE) && in_valid;
        cmd.init  = (state_reg == ST_INIT);
        cmd.find  = (state_reg == ST_FIND);
        cmd.emit  = (state_reg == ST_EMIT) && status.out_free;
        cmd.relax = (state_reg == ST_RELAX);
    end

endmodule

// ----- rtl/core/pmst_dpath.sv -----
// Datapath for the Prim minimum spanning tree block: weight memory, per-vertex
// keys, parents and tree flags, scan counters and the result register.
// Depends on pmst_pkg; driven by pmst_ctrl commands.
module pmst_dpath #(
    parameter int MAX_VERTICES = pmst_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = pmst_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pmst_pkg::cmd_t                       cmd,
    output pmst_pkg::status_t                    status,
    input  logic [pmst_pkg::VERTEX_FIELD_W-1:0]  row,
    input  logic [pmst_pkg::VERTEX_FIELD_W-1:0]  col,
    input  logic [pmst_pkg::WEIGHT_FIELD_W-1:0]  weight,
    input  logic [pmst_pkg::VCOUNT_W-1:0]        vertex_count,
    input  logic [pmst_pkg::VERTEX_FIELD_W-1:0]  root_vertex,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pmst_pkg::VERTEX_FIELD_W-1:0]  vertex,
    output logic [pmst_pkg::VERTEX_FIELD_W-1:0]  parent,
    output logic                                 is_root,
    output logic [pmst_pkg::WEIGHT_FIELD_W-1:0]  edge_weight,
    output logic                                 done_res
);
    import pmst_pkg::*;

    localparam int LIMIT     = (MAX_VERTICES < VERTEX_CAP) ? MAX_VERTICES : VERTEX_CAP;
    localparam int IDX_W     = $clog2(LIMIT);
    localparam int KEY_W     = WEIGHT_BITS + 1;
    localparam int MEM_DEPTH = 2 ** (2 * IDX_W);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [KEY_W-1:0] key_t;

    // The matrix is symmetric, so each pair is kept once under (lower, higher).
    logic [WEIGHT_BITS-1:0] mem [MEM_DEPTH];

    key_t key_reg     [LIMIT];
    idx_t par_reg     [LIMIT];
    logic in_tree_reg [LIMIT];

    idx_t last_idx_reg;
    idx_t root_reg;
    idx_t pick_reg;
    idx_t scan_reg;
    idx_t round_reg;

    logic best_found_reg;
    idx_t best_idx_reg;
    key_t best_key_reg;
    idx_t best_par_reg;

    logic                   rd_pend_reg;
    idx_t                   rd_v_reg;
    key_t                   rd_key_reg;
    logic                   rd_in_tree_reg;
    logic [WEIGHT_BITS-1:0] rd_data_reg;

    logic out_valid_reg;
    logic [VERTEX_FIELD_W-1:0] vertex_reg;
    logic [VERTEX_FIELD_W-1:0] parent_reg;
    logic                      is_root_reg;
    logic [WEIGHT_FIELD_W-1:0] edge_weight_reg;
    logic                      done_reg;

    logic                   row_ok;
    logic                   col_ok;
    logic                   wr_en;
    idx_t                   wr_lo;
    idx_t                   wr_hi;
    logic [WEIGHT_BITS-1:0] wr_data;
    idx_t                   rd_lo;
    idx_t                   rd_hi;
    logic [VCOUNT_W-1:0]    n_used;
    idx_t                   last_idx_next;
    idx_t                   root_next;
    key_t                   scan_key;
    logic                   scan_take;
    logic                   relax_take;
    logic                   emit_root;

    // Load path and weight memory read address.
    always_comb
    begin
        row_ok  = ({1'b0, row} < VCOUNT_W'(LIMIT));
        col_ok  = ({1'b0, col} < VCOUNT_W'(LIMIT));
        wr_en   = cmd.load && row_ok && col_ok;
        wr_lo   = (row < col) ? IDX_W'(row) : IDX_W'(col);
        wr_hi   = (row < col) ? IDX_W'(col) : IDX_W'(row);
        wr_data = WEIGHT_BITS'(weight);
        rd_lo   = (scan_reg < pick_reg) ? scan_reg : pick_reg;
        rd_hi   = (scan_reg < pick_reg) ? pick_reg : scan_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_lo, wr_hi}] <= wr_data;
        end
        rd_data_reg <= mem[{rd_lo, rd_hi}];
    end

    // Vertex count is clamped to the usable range, and an unusable root falls back to zero.
    always_comb
    begin
        priority if (vertex_count < VCOUNT_W'(2))
        begin
            n_used = VCOUNT_W'(2);
        end
        else if (vertex_count > VCOUNT_W'(LIMIT))
        begin
            n_used = VCOUNT_W'(LIMIT);
        end
        else
        begin
            n_used = vertex_count;
        end
        last_idx_next = IDX_W'(n_used - VCOUNT_W'(1));
        root_next     = ({1'b0, root_vertex} < n_used) ? IDX_W'(root_vertex) : '0;
    end

    always_comb
    begin
        scan_key   = key_reg[scan_reg];
        scan_take  = !in_tree_reg[scan_reg] && (!best_found_reg || (scan_key < best_key_reg));
        relax_take = rd_pend_reg && !rd_in_tree_reg && (rd_key_reg > {1'b0, rd_data_reg});
        emit_root  = (best_idx_reg == root_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_idx_reg   <= '0;
            root_reg       <= '0;
            pick_reg       <= '0;
            scan_reg       <= '0;
            round_reg      <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_key_reg   <= '0;
            best_par_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            rd_v_reg       <= '0;
            rd_key_reg     <= '0;
            rd_in_tree_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.relax;
            if (cmd.relax)
            begin
                rd_v_reg       <= scan_reg;
                rd_key_reg     <= scan_key;
                rd_in_tree_reg <= in_tree_reg[scan_reg];
            end
            if (cmd.init)
            begin
                last_idx_reg   <= last_idx_next;
                root_reg       <= root_next;
                scan_reg       <= '0;
                round_reg      <= '0;
                best_found_reg <= 1'b0;
            end
            if (cmd.find || cmd.relax)
            begin
                scan_reg <= (scan_reg == last_idx_reg) ? '0 : scan_reg + IDX_W'(1);
            end
            if (cmd.find && scan_take)
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= scan_reg;
                best_key_reg   <= scan_key;
                best_par_reg   <= par_reg[scan_reg];
            end
            if (cmd.emit)
            begin
                pick_reg       <= best_idx_reg;
                best_found_reg <= 1'b0;
                round_reg      <= round_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIMIT; i++)
            begin
                key_reg[i]     <= '1;
                par_reg[i]     <= '0;
                in_tree_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.init)
            begin
                for (int i = 0; i < LIMIT; i++)
                begin
                    key_reg[i]     <= (idx_t'(i) == root_next) ? key_t'(0) : {KEY_W{1'b1}};
                    par_reg[i]     <= '0;
                    in_tree_reg[i] <= 1'b0;
                end
            end
            if (relax_take)
            begin
                key_reg[rd_v_reg] <= {1'b0, rd_data_reg};
                par_reg[rd_v_reg] <= pick_reg;
            end
            if (cmd.emit)
            begin
                in_tree_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    // Result register: a new request may be loaded in the cycle the old one is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            vertex_reg      <= VERTEX_FIELD_W'(best_idx_reg);
            is_root_reg     <= emit_root;
            parent_reg      <= emit_root ? '0 : VERTEX_FIELD_W'(best_par_reg);
            edge_weight_reg <= emit_root ? '0 : WEIGHT_FIELD_W'(best_key_reg);
            done_reg        <= (round_reg == last_idx_reg);
        end
    end

    always_comb
    begin
        status.scan_last  = (scan_reg == last_idx_reg);
        status.round_last = (round_reg == last_idx_reg);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid   = out_valid_reg;
    assign vertex      = vertex_reg;
    assign parent      = parent_reg;
    assign is_root     = is_root_reg;
    assign edge_weight = edge_weight_reg;
    assign done_res    = done_reg;

endmodule

// ----- rtl/core/prim_minimum_spanning_tree.sv -----
// Prim minimum spanning tree top level. Load requests are taken back to back while the block is
// idle. After the last load: a setup state, then in each round a minimum search over the n
// vertices in use and an issue state (held while the result register is stalled), and in every
// round but the last a relaxation pass over the n vertices and a drain state. Loads are stalled
// for the whole build. Reset is asynchronous; the weight memory is not cleared and must be
// written before a build.
module prim_minimum_spanning_tree #(
    parameter int MAX_VERTICES = pmst_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = pmst_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [pmst_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pmst_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pmst_pkg::VERTEX_FIELD_W-1:0]  row,
    input  logic [pmst_pkg::VERTEX_FIELD_W-1:0]  col,
    input  logic [pmst_pkg::WEIGHT_FIELD_W-1:0]  weight,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pmst_pkg::VERTEX_FIELD_W-1:0]  vertex,
    output logic [pmst_pkg::VERTEX_FIELD_W-1:0]  parent,
    output logic                                 is_root,
    output logic [pmst_pkg::WEIGHT_FIELD_W-1:0]  edge_weight,
    output logic                                 done_res
);
    import pmst_pkg::*;

    logic [VCOUNT_W-1:0]       vertex_count_reg;
    logic [VERTEX_FIELD_W-1:0] root_vertex_reg;
    cmd_t                      cmd;
    status_t                   status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VCOUNT_RESET;
            root_vertex_reg  <= ROOT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT: vertex_count_reg <= VCOUNT_W'(cfg_data);
                CFG_ROOT_VERTEX:  root_vertex_reg  <= VERTEX_FIELD_W'(cfg_data);
                default:          vertex_count_reg <= vertex_count_reg;
            endcase
        end
    end

    pmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last),
        .status   (status),
        .cmd      (cmd)
    );

    pmst_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .row          (row),
        .col          (col),
        .weight       (weight),
        .vertex_count (vertex_count_reg),
        .root_vertex  (root_vertex_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vertex       (vertex),
        .parent       (parent),
        .is_root      (is_root),
        .edge_weight  (edge_weight),
        .done_res     (done_res)
    );

    assign in_stall = cmd.busy;

    // A final load starts a build, so loads are held off on the next cycle.
    a_last_starts_build: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("build did not start after the final load");

    // After the final result is taken, nothing more is pending.
    a_done_empties: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && done_res |=> !out_valid)
        else $error("result pending after the final vertex");

    // A stalled result stays valid and keeps its fields.
    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({vertex, parent, is_root, edge_weight, done_res}))
        else $error("stalled result changed");

endmodule
